// ----- hw/rtl/sgr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, character codes and attribute decode for the SGR parser.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // character codes
  localparam logic [7:0] ESC_BYTE      = 8'd27;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_M        = 8'h6D;
  localparam logic [7:0] CHAR_SEMI     = 8'h3B;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;

  // sgr code values
  localparam logic [9:0] CODE_MAX       = 10'd999;
  localparam logic [9:0] SGR_RESET      = 10'd0;
  localparam logic [9:0] SGR_BOLD       = 10'd1;
  localparam logic [9:0] SGR_NORMAL     = 10'd22;
  localparam logic [9:0] SGR_FG_FIRST   = 10'd30;
  localparam logic [9:0] SGR_FG_LAST    = 10'd37;
  localparam logic [9:0] SGR_FG_DEFAULT = 10'd39;
  localparam logic [9:0] SGR_HI_FIRST   = 10'd90;
  localparam logic [9:0] SGR_HI_LAST    = 10'd97;
  localparam logic [3:0] FG_PAIR_BASE   = 4'd2;

  // escape parse mode
  typedef enum logic [2:0] {
    MODE_TEXT = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_CSI  = 3'b100
  } mode_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_LIT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [3:0] pair;
    logic       bold;
  } attr_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic prep;
    logic flush_pop;
    logic lit_pop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_flush;
    logic out_free;
    logic flush_last;
    logic lit_pend;
  } sts_t;

  // apply one sgr code to an attribute
  function automatic attr_t apply_code(input logic [9:0] code, input attr_t cur);
    attr_t r;
    r = cur;
    if (code == SGR_RESET) begin
      r.pair = 4'd0;
      r.bold = 1'b0;
    end else if (code == SGR_BOLD) begin
      r.bold = 1'b1;
    end else if (code == SGR_NORMAL) begin
      r.bold = 1'b0;
    end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
      r.pair = FG_PAIR_BASE + 4'(code - SGR_FG_FIRST);
    end else if (code == SGR_FG_DEFAULT) begin
      r.pair = 4'd0;
    end else if (code >= SGR_HI_FIRST && code <= SGR_HI_LAST) begin
      r.pair = FG_PAIR_BASE + 4'(code - SGR_HI_FIRST);
      r.bold = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sgr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_ctrl
// Sequencer: takes bytes, then walks the parameter flush and trailing literal.
// ----------------------------------------------------------------------------
module sgr_ctrl
  import sgr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // handshake and commands
  assign in_ready      = (state == ST_IDLE) && sts.out_free;
  assign cmd.accept    = in_valid && in_ready;
  assign cmd.prep      = (state == ST_PREP);
  assign cmd.flush_pop = (state == ST_FLUSH) && sts.out_free;
  assign cmd.lit_pop   = (state == ST_LIT) && sts.out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.go_flush) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (cmd.flush_pop && sts.flush_last) begin
          state_next = sts.lit_pend ? ST_LIT : ST_IDLE;
        end
      end
      ST_LIT: begin
        if (cmd.lit_pop) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // checks
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && sts.go_flush |=> state == ST_PREP)
    else $error("flush did not start after a malformed sequence");

  a_prep_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_PREP |=> state == ST_FLUSH)
    else $error("prefetch cycle not followed by flush");

  a_lit_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_LIT |-> sts.lit_pend)
    else $error("literal state without pending literal");

endmodule

// ----- hw/rtl/sgr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_dp
// Datapath: escape decode, attribute registers, parameter buffer, result reg.
// ----------------------------------------------------------------------------
module sgr_dp
  import sgr_pkg::*;
#(
  parameter int PARAM_DEPTH = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic [3:0] fg_pair,
  output logic       bold,
  output logic       last_of_run
);

  localparam int CNT_W = $clog2(PARAM_DEPTH + 1);
  localparam int IDX_W = $clog2(PARAM_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PARAM_DEPTH);

  // parse state
  mode_t            mode, mode_next;
  attr_t            live, live_next;
  attr_t            shadow, shadow_next;
  logic [9:0]       code, code_next;
  logic [CNT_W-1:0] count, count_next;

  // flush bookkeeping
  logic [CNT_W-1:0] flush_len;
  logic [CNT_W-1:0] idx;
  logic [7:0]       lit_byte;
  logic             lit_pend;

  // buffer memory
  logic [7:0]       mem [PARAM_DEPTH];
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] rd_addr;

  // decode results for the offered byte
  logic             wr_en;
  logic             emit;
  logic [CNT_W-1:0] flush_n;
  logic             is_digit;
  logic             is_sep;
  logic [13:0]      code_wide;
  logic             out_load;

  assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign is_sep    = (in_byte == CHAR_SEMI);
  assign code_wide = {1'b0, code, 3'b000} + {3'b000, code, 1'b0} + {6'd0, in_byte - CHAR_ZERO};

  // byte decode
  always_comb begin
    mode_next   = mode;
    live_next   = live;
    shadow_next = shadow;
    code_next   = code;
    count_next  = count;
    wr_en       = 1'b0;
    emit        = 1'b0;
    flush_n     = '0;
    case (mode)
      MODE_ESC: begin
        if (in_byte == CHAR_LBRACKET) begin
          mode_next   = MODE_CSI;
          shadow_next = live;
          code_next   = '0;
          count_next  = '0;
        end else if (in_byte == ESC_BYTE) begin
          mode_next = MODE_ESC;
        end else begin
          mode_next = MODE_TEXT;
          emit      = 1'b1;
        end
      end
      MODE_CSI: begin
        if (in_byte == CHAR_M) begin
          live_next  = apply_code(code, shadow);
          code_next  = '0;
          count_next = '0;
          mode_next  = MODE_TEXT;
        end else if (is_digit || is_sep) begin
          if (count >= DEPTH_C) begin
            // buffer overflow: flush, then the byte itself as a literal
            flush_n    = count;
            count_next = '0;
            code_next  = '0;
            mode_next  = MODE_TEXT;
            emit       = 1'b1;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
            if (is_digit) begin
              code_next = (code_wide > 14'(CODE_MAX)) ? CODE_MAX : code_wide[9:0];
            end else begin
              shadow_next = apply_code(code, shadow);
              code_next   = '0;
            end
          end
        end else begin
          // malformed sequence: flush, then handle as plain text
          flush_n    = count;
          count_next = '0;
          code_next  = '0;
          if (in_byte == ESC_BYTE) begin
            mode_next = MODE_ESC;
          end else begin
            mode_next = MODE_TEXT;
            emit      = 1'b1;
          end
        end
      end
      default: begin
        if (in_byte == ESC_BYTE) begin
          mode_next = MODE_ESC;
        end else begin
          mode_next = MODE_TEXT;
          emit      = 1'b1;
        end
      end
    endcase
    // end of text flushes a pending sequence
    if (end_of_text) begin
      if (mode_next == MODE_CSI) flush_n = count_next;
      mode_next  = MODE_TEXT;
      code_next  = '0;
      count_next = '0;
    end
  end

  // status
  assign sts.go_flush   = (flush_n != '0);
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.flush_last = ((idx + 1'b1) == flush_len);
  assign sts.lit_pend   = lit_pend;

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_TEXT;
      live   <= '0;
      shadow <= '0;
      code   <= '0;
      count  <= '0;
    end else if (cmd.accept) begin
      mode   <= mode_next;
      live   <= live_next;
      shadow <= shadow_next;
      code   <= code_next;
      count  <= count_next;
    end
  end

  // flush bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      lit_pend  <= 1'b0;
      flush_len <= '0;
      idx       <= '0;
    end else begin
      if (cmd.accept) begin
        lit_pend  <= emit && (flush_n != '0);
        flush_len <= flush_n;
      end else if (cmd.lit_pop) begin
        lit_pend <= 1'b0;
      end
      if (cmd.prep) idx <= '0;
      else if (cmd.flush_pop) idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) lit_byte <= in_byte;
  end

  // parameter buffer, registered read
  always_comb begin
    if (cmd.prep) rd_addr = '0;
    else if (cmd.flush_pop) rd_addr = idx + 1'b1;
    else rd_addr = idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) mem[count[IDX_W-1:0]] <= in_byte;
    rd_data <= mem[rd_addr[IDX_W-1:0]];
  end

  // result register
  assign out_load = (cmd.accept && emit && (flush_n == '0)) || cmd.flush_pop || cmd.lit_pop;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_pop) begin
      out_char    <= rd_data;
      last_of_run <= sts.flush_last && !lit_pend;
    end else if (cmd.lit_pop) begin
      out_char    <= lit_byte;
      last_of_run <= 1'b1;
    end else if (out_load) begin
      out_char    <= in_byte;
      last_of_run <= 1'b1;
    end
    if (out_load) begin
      fg_pair <= live.pair;
      bold    <= live.bold;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("parameter count beyond buffer depth");

  a_flush_range: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_pop |-> idx < flush_len)
    else $error("flush read past buffered bytes");

  a_idle_csi: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && end_of_text |=> mode == MODE_TEXT && count == '0)
    else $error("end of text left a pending sequence");

endmodule

// ----- hw/rtl/ansi_sgr_attribute_parser.sv -----
`timescale 1ns / 1ps
// A text byte needing no flush is in the output register in the cycle after it is taken.
// One byte is taken per cycle for text and escape bytes while the output drains.
// A malformed or truncated sequence with N buffered bytes is flushed via a prep state, then
// one read per cycle while the output drains, then any trailing literal; no byte is taken.
// Reset (rst, synchronous, active high) clears parse mode, attributes, code and counts;
// the parameter buffer is not cleared.
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser
// Splits a byte stream into literals tagged with the SGR color pair and bold.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser
  import sgr_pkg::*;
#(
  parameter int PARAM_DEPTH = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic [3:0] fg_pair,
  output logic       bold,
  output logic       last_of_run
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sgr_dp #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .fg_pair     (fg_pair),
    .bold        (bold),
    .last_of_run (last_of_run)
  );

endmodule

// ----- tb/tb_ansi_sgr_attribute_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_sgr_attribute_parser
// Drives byte streams with SGR escape sequences through the parser. A behavioral
// decoder predicts the tagged literals of each accepted byte (directed rows may state
// them instead), and every output transaction is checked against them in order.
// ----------------------------------------------------------------------------
module tb_ansi_sgr_attribute_parser;
  import sgr_pkg::*;

  localparam int DEPTH          = 31;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = 80;

  // one tagged literal as seen on the output
  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] pair;
    logic       bold;
    logic       last;
  } glyph_t;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_ONE,
    ROW_NONE
  } row_kind_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
    row_kind_t  kind;
    logic [7:0] ch;
    logic [3:0] pair;
    logic       bold;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_text;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic [3:0] fg_pair;
  logic       bold;
  logic       last_of_run;

  // decoder state
  mode_t      dec_mode;
  attr_t      live_attr;
  attr_t      shadow_attr;
  logic [9:0] code_val;
  logic [7:0] param_bytes [DEPTH];
  int         param_cnt;

  glyph_t     run_q [$];
  glyph_t     glyph_q [$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         sent_count = 0;
  bit         idle_on = 1'b1;

  // directed stream: extremes, bright color, empty code, malformed, lone escape, truncation
  stim_row_t directed_rows [24] = '{
    '{"A",           1'b0, ROW_ONE,     "A",   4'd0, 1'b0},
    '{8'h00,         1'b0, ROW_ONE,     8'h00, 4'd0, 1'b0},
    '{8'hFF,         1'b0, ROW_ONE,     8'hFF, 4'd0, 1'b0},
    '{ESC_BYTE,      1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{CHAR_LBRACKET, 1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"9",           1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"7",           1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{CHAR_M,        1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"x",           1'b0, ROW_ONE,     "x",   4'd9, 1'b1},
    '{ESC_BYTE,      1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{CHAR_LBRACKET, 1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{CHAR_SEMI,     1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"3",           1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"0",           1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{CHAR_M,        1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{ESC_BYTE,      1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{CHAR_LBRACKET, 1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"1",           1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"q",           1'b0, ROW_PREDICT, 8'h00, 4'd0, 1'b0},
    '{ESC_BYTE,      1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"z",           1'b0, ROW_ONE,     "z",   4'd2, 1'b0},
    '{ESC_BYTE,      1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{CHAR_LBRACKET, 1'b0, ROW_NONE,    8'h00, 4'd0, 1'b0},
    '{"5",           1'b1, ROW_PREDICT, 8'h00, 4'd0, 1'b0}
  };

  ansi_sgr_attribute_parser #(
    .PARAM_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .fg_pair    (fg_pair),
    .bold       (bold),
    .last_of_run(last_of_run)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // decoder
  // ---------------------------------------------------------------------------

  function automatic void emit_glyph(input logic [7:0] c);
    glyph_t g;
    g = '{c, live_attr.pair, live_attr.bold, 1'b0};
    run_q.insert(run_q.size(), g);
  endfunction

  // update the shadow attribute with one finished code
  function automatic void take_code(input logic [9:0] c);
    if (c == SGR_RESET) begin
      shadow_attr = '0;
    end else if (c == SGR_BOLD) begin
      shadow_attr.bold = 1'b1;
    end else if (c == SGR_NORMAL) begin
      shadow_attr.bold = 1'b0;
    end else if (c >= SGR_FG_FIRST && c <= SGR_FG_LAST) begin
      shadow_attr.pair = 4'(c - SGR_FG_FIRST) + FG_PAIR_BASE;
    end else if (c == SGR_FG_DEFAULT) begin
      shadow_attr.pair = 4'd0;
    end else if (c >= SGR_HI_FIRST && c <= SGR_HI_LAST) begin
      shadow_attr.pair = 4'(c - SGR_HI_FIRST) + FG_PAIR_BASE;
      shadow_attr.bold = 1'b1;
    end
  endfunction

  // re-emit buffered parameter text as literals
  function automatic void spill_params();
    for (int i = 0; i < param_cnt; i++) emit_glyph(param_bytes[i]);
    param_cnt = 0;
    code_val  = '0;
  endfunction

  function automatic void text_byte(input logic [7:0] b);
    if (b == ESC_BYTE) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_TEXT;
      emit_glyph(b);
    end
  endfunction

  // expected literals for one accepted byte, left in run_q
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    bit is_digit;
    int acc;
    is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
    run_q.delete();
    if (dec_mode == MODE_ESC) begin
      if (b == CHAR_LBRACKET) begin
        dec_mode    = MODE_CSI;
        shadow_attr = live_attr;
        code_val    = '0;
        param_cnt   = 0;
      end else begin
        text_byte(b);
      end
    end else if (dec_mode == MODE_CSI) begin
      if (b == CHAR_M) begin
        take_code(code_val);
        live_attr = shadow_attr;
        code_val  = '0;
        param_cnt = 0;
        dec_mode  = MODE_TEXT;
      end else if (is_digit || b == CHAR_SEMI) begin
        if (param_cnt >= DEPTH) begin
          // buffer full: treated as malformed
          spill_params();
          dec_mode = MODE_TEXT;
          emit_glyph(b);
        end else begin
          param_bytes[param_cnt] = b;
          param_cnt++;
          if (is_digit) begin
            acc = int'(code_val) * 10 + int'(b - CHAR_ZERO);
            code_val = (acc > int'(CODE_MAX)) ? CODE_MAX : 10'(acc);
          end else begin
            take_code(code_val);
            code_val = '0;
          end
        end
      end else begin
        spill_params();
        text_byte(b);
      end
    end else begin
      text_byte(b);
    end
    // end of string flushes whatever is pending
    if (eot) begin
      if (dec_mode == MODE_CSI) spill_params();
      dec_mode  = MODE_TEXT;
      code_val  = '0;
      param_cnt = 0;
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // called at a falling edge; returns at a falling edge after the transaction
  task automatic send_row(input stim_row_t row);
    glyph_t g;
    while (idle_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= row.b;
    end_of_text <= row.eot;
    do @(posedge clk); while (!in_ready);
    decode_byte(row.b, row.eot);
    case (row.kind)
      ROW_PREDICT: foreach (run_q[i]) glyph_q.insert(glyph_q.size(), run_q[i]);
      ROW_ONE: begin
        g = '{row.ch, row.pair, row.bold, 1'b1};
        glyph_q.insert(glyph_q.size(), g);
      end
      default:     ;
    endcase
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eot);
    stim_row_t row;
    row = '{b, eot, ROW_PREDICT, 8'h00, 4'd0, 1'b0};
    send_row(row);
  endtask

  function automatic logic rand_eot();
    return ($urandom_range(99) < 3);
  endfunction

  task automatic send_number(input int v);
    int digits [$];
    do begin
      digits.push_front(v % 10);
      v = v / 10;
    end while (v > 0);
    if ($urandom_range(9) == 0) digits.push_front(0);
    foreach (digits[i]) send_byte(CHAR_ZERO + 8'(digits[i]), rand_eot());
  endtask

  // one escape sequence with random codes; broken ends on a random byte
  task automatic send_sgr(input bit broken);
    int n_codes;
    int pick;
    send_byte(ESC_BYTE, rand_eot());
    send_byte(CHAR_LBRACKET, rand_eot());
    n_codes = $urandom_range(0, 4);
    for (int i = 0; i < n_codes; i++) begin
      if (i > 0) send_byte(CHAR_SEMI, rand_eot());
      pick = $urandom_range(9);
      case (pick)
        0: ;  // empty code
        1: send_number(0);
        2: send_number(1);
        3: send_number(22);
        4: send_number(30 + $urandom_range(7));
        5: send_number(39);
        6: send_number(90 + $urandom_range(7));
        7: send_number($urandom_range(9999));
        8: send_number($urandom_range(99));
        default: send_number($urandom_range(1) ? 29 + 9 * $urandom_range(1)
                                               : 89 + 9 * $urandom_range(1));
      endcase
    end
    if (broken) send_byte(8'($urandom_range(255)), rand_eot());
    else        send_byte(CHAR_M, rand_eot());
  endtask

  // parameter text near and past the buffer depth
  task automatic send_long_params();
    int n;
    send_byte(ESC_BYTE, 1'b0);
    send_byte(CHAR_LBRACKET, 1'b0);
    n = $urandom_range(DEPTH - 3, DEPTH + 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_byte(CHAR_SEMI, 1'b0);
      else                        send_byte(CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
    end
    if ($urandom_range(1)) send_byte(CHAR_M, rand_eot());
    else                   send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 37);
  end

  // compare each output transaction with the oldest expected literal
  always @(posedge clk) begin
    glyph_t exp_g;
    if (!rst && out_valid && out_ready) begin
      if (glyph_q.size() == 0) begin
        report_error($sformatf("unexpected output char 0x%02h", out_char));
      end else begin
        exp_g = glyph_q.pop_front();
        if (out_char !== exp_g.ch)
          report_error($sformatf("out_char 0x%02h, want 0x%02h", out_char, exp_g.ch));
        if (fg_pair !== exp_g.pair)
          report_error($sformatf("fg_pair %0d, want %0d", fg_pair, exp_g.pair));
        if (bold !== exp_g.bold)
          report_error($sformatf("bold %0b, want %0b", bold, exp_g.bold));
        if (last_of_run !== exp_g.last)
          report_error($sformatf("last_of_run %0b, want %0b", last_of_run, exp_g.last));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int seg;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    end_of_text = 1'b0;
    dec_mode    = MODE_TEXT;
    live_attr   = '0;
    shadow_attr = '0;
    code_val    = '0;
    param_cnt   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    foreach (directed_rows[i]) send_row(directed_rows[i]);

    // random segments, with a stretch of no idling in the middle
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      idle_on = !(sent_count >= 150 && sent_count < 250);
      seg = $urandom_range(99);
      if (seg < 35) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), rand_eot());
      end else if (seg < 75) begin
        send_sgr(1'b0);
      end else if (seg < 83) begin
        send_sgr(1'b1);
      end else if (seg < 90) begin
        send_long_params();
      end else begin
        // lone escape, sometimes doubled
        send_byte(ESC_BYTE, rand_eot());
        if ($urandom_range(2) == 0) send_byte(ESC_BYTE, rand_eot());
        send_byte(8'($urandom_range(255)), rand_eot());
      end
    end
    in_valid    <= 1'b0;
    end_of_text <= 1'b0;
    idle_on      = 1'b1;

    // wait for outstanding literals, then let the block settle
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_ctrl.sv
hw/rtl/sgr_dp.sv
hw/rtl/ansi_sgr_attribute_parser.sv
tb/tb_ansi_sgr_attribute_parser.sv
